@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the envelope unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/pfp_pkg.sv @@
// Types and constants shared by the envelope unit modules
package pfp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RAMP_W   = 24;
  localparam int COUNT_W  = 30;
  localparam int CFG_W    = 30;
  localparam int ADDR_W   = 2;
  localparam int QBITS    = 16;                 // quotient bits per divide
  localparam int STEP_W   = $clog2(QBITS);
  localparam int PROD_W   = RAMP_W + QBITS;     // |sample| * num stays below 2^39

  localparam logic [ADDR_W-1:0] REG_EFFECT_MODE  = 2'd0;
  localparam logic [ADDR_W-1:0] REG_STEREO       = 2'd1;
  localparam logic [ADDR_W-1:0] REG_RAMP_FRAMES  = 2'd2;
  localparam logic [ADDR_W-1:0] REG_TOTAL_FRAMES = 2'd3;

  localparam logic [1:0] MODE_FADE_IN  = 2'd0;
  localparam logic [1:0] MODE_FADE_OUT = 2'd1;
  localparam logic [1:0] MODE_PAN      = 2'd2;

  typedef struct packed {
    logic load;      // item accepted
    logic mul;       // form product for chan
    logic step;      // one divide step
    logic store;     // keep quotient for chan
    logic publish;   // move result to output register
    logic chan;      // 0 left, 1 right
  } pfp_cmd_t;

  typedef struct packed {
    logic scale_en;
    logic div_last;
    logic out_free;
  } pfp_status_t;

endpackage

@@ rtl/core/pfp_ctrl.sv @@
// Sequencer for the envelope unit: accept, multiply, divide, publish
`include "assert_macros.svh"

module pfp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pfp_pkg::pfp_status_t status,
  output pfp_pkg::pfp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_FINISH
  } state_t;

  state_t state;
  logic   chan;

  always_comb begin
    cmd      = '0;
    cmd.chan = chan;
    cmd.load = in_valid && !in_stall;
    unique case (state)
      ST_MUL:    cmd.mul = 1'b1;
      ST_DIV:    cmd.step = 1'b1;
      ST_STORE:  cmd.store = 1'b1;
      ST_FINISH: cmd.publish = status.out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_stall <= 1'b0;
      chan     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            state    <= ST_DECIDE;
            in_stall <= 1'b1;
          end
        end
        ST_DECIDE: begin
          chan  <= 1'b0;
          state <= status.scale_en ? ST_MUL : ST_FINISH;
        end
        ST_MUL: state <= ST_DIV;
        ST_DIV: begin
          if (status.div_last) state <= ST_STORE;
        end
        ST_STORE: begin
          if (!chan) begin
            chan  <= 1'b1;
            state <= ST_MUL;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (status.out_free) begin
            state    <= ST_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_ready_only_idle, clk, rst, 1'b1, ((state == ST_IDLE) == !in_stall))
  `ASSERT_NEXT(a_div_then_store, clk, rst, (cmd.step && status.div_last), (state == ST_STORE))
  `ASSERT_NEXT(a_right_then_finish, clk, rst, (state == ST_STORE && chan), (state == ST_FINISH))

endmodule

@@ rtl/core/pfp_dp.sv @@
// Datapath: registers, frame counters, gain decision, multiplier and divider
`include "assert_macros.svh"

module pfp_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_en,
  input  logic [pfp_pkg::ADDR_W-1:0]            cfg_addr,
  input  logic [pfp_pkg::CFG_W-1:0]             cfg_data,
  input  logic signed [pfp_pkg::SAMPLE_W-1:0]   left_sample,
  input  logic signed [pfp_pkg::SAMPLE_W-1:0]   right_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pfp_pkg::SAMPLE_W-1:0]   left_out,
  output logic signed [pfp_pkg::SAMPLE_W-1:0]   right_out,
  output logic                                  mode_error,
  input  pfp_pkg::pfp_cmd_t                     cmd,
  output pfp_pkg::pfp_status_t                  status
);

  localparam int SW = pfp_pkg::SAMPLE_W;
  localparam int RW = pfp_pkg::RAMP_W;
  localparam int CW = pfp_pkg::COUNT_W;
  localparam int QB = pfp_pkg::QBITS;
  localparam int PW = pfp_pkg::PROD_W;

  // configuration
  logic [1:0]    effect_mode;
  logic          stereo;
  logic [RW-1:0] ramp_frames;
  logic [CW-1:0] total_frames;

  // frame state
  logic [CW-1:0] frames_seen;
  logic [CW-1:0] ramp_position;

  // decision for the incoming item
  logic          dec_scale;
  logic          dec_zero_l;
  logic          dec_err;
  logic          dec_bump_q;
  logic [RW-1:0] dec_num_l;
  logic [RW-1:0] dec_num_r;
  logic [CW:0]   end_sum;
  logic [CW-1:0] fade_num;

  // latched item
  logic signed [SW-1:0] sample_l;
  logic signed [SW-1:0] sample_r;
  logic [RW-1:0]        num_l;
  logic [RW-1:0]        num_r;
  logic [RW-1:0]        den;
  logic                 scale_en;
  logic                 zero_l;
  logic                 err;

  // divider
  logic signed [SW:0]           mul_s;
  logic [SW:0]                  mul_mag;
  logic [RW-1:0]                mul_num;
  logic [PW:0]                  prod;
  logic                         neg;
  logic [RW-1:0]                rem;
  logic [QB-1:0]                qsh;
  logic [pfp_pkg::STEP_W-1:0]   step_cnt;
  logic [RW:0]                  trial;
  logic                         ge;
  logic signed [SW-1:0]         quot;
  logic signed [SW-1:0]         res_l;
  logic signed [SW-1:0]         res_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode  <= pfp_pkg::MODE_FADE_IN;
      stereo       <= 1'b1;
      ramp_frames  <= '0;
      total_frames <= '0;
    end else if (cfg_en) begin
      unique case (cfg_addr)
        pfp_pkg::REG_EFFECT_MODE:  effect_mode <= cfg_data[1:0];
        pfp_pkg::REG_STEREO:       stereo <= cfg_data[0];
        pfp_pkg::REG_RAMP_FRAMES:  ramp_frames <= cfg_data[RW-1:0];
        pfp_pkg::REG_TOTAL_FRAMES: total_frames <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  assign end_sum  = {1'b0, frames_seen} + (CW+1)'(ramp_frames);
  assign fade_num = total_frames - frames_seen - CW'(1);

  always_comb begin
    dec_scale  = 1'b0;
    dec_zero_l = 1'b0;
    dec_err    = 1'b0;
    dec_bump_q = 1'b0;
    dec_num_l  = ramp_position[RW-1:0];
    dec_num_r  = ramp_position[RW-1:0];
    case (effect_mode)
      pfp_pkg::MODE_FADE_IN: begin
        if (ramp_position < CW'(ramp_frames)) begin
          dec_scale  = 1'b1;
          dec_bump_q = 1'b1;
        end
      end
      pfp_pkg::MODE_FADE_OUT: begin
        if (frames_seen < total_frames && end_sum >= {1'b0, total_frames}) begin
          // ramp is nonzero here, and the numerator stays below it
          dec_scale = 1'b1;
          dec_num_l = fade_num[RW-1:0];
          dec_num_r = fade_num[RW-1:0];
        end
      end
      pfp_pkg::MODE_PAN: begin
        if (!stereo) begin
          dec_err    = 1'b1;
          dec_bump_q = 1'b1;
        end else if (frames_seen < total_frames) begin
          if (ramp_position < CW'(ramp_frames)) begin
            dec_scale  = 1'b1;
            dec_bump_q = 1'b1;
            dec_num_l  = ramp_frames - ramp_position[RW-1:0] - RW'(1);
          end else begin
            dec_zero_l = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // counters advance at accept; the user must hold config static while items are in flight (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen   <= '0;
      ramp_position <= '0;
    end else if (cmd.load) begin
      if (frames_seen != '1) frames_seen <= frames_seen + CW'(1);
      if (dec_bump_q && ramp_position != '1) ramp_position <= ramp_position + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_l <= left_sample;
      sample_r <= stereo ? right_sample : '0;
      num_l    <= dec_num_l;
      num_r    <= dec_num_r;
      den      <= ramp_frames;
      scale_en <= dec_scale;
      zero_l   <= dec_zero_l;
      err      <= dec_err;
    end
  end

  // magnitude product, then restoring divide: quotient is known below 2^16
  assign mul_s   = cmd.chan ? {sample_r[SW-1], sample_r} : {sample_l[SW-1], sample_l};
  assign mul_mag = mul_s[SW] ? (SW+1)'(-mul_s) : (SW+1)'(mul_s);
  assign mul_num = cmd.chan ? num_r : num_l;
  assign prod    = (PW+1)'(mul_mag) * (PW+1)'(mul_num);

  assign trial = {rem, qsh[QB-1]} - {1'b0, den};
  assign ge    = !trial[RW];
  assign quot  = neg ? -$signed(qsh) : $signed(qsh);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      neg      <= mul_s[SW];
      rem      <= prod[PW-1:QB];
      qsh      <= prod[QB-1:0];
      step_cnt <= '0;
    end else if (cmd.step) begin
      rem      <= ge ? trial[RW-1:0] : {rem[RW-2:0], qsh[QB-1]};
      qsh      <= {qsh[QB-2:0], ge};
      step_cnt <= step_cnt + pfp_pkg::STEP_W'(1);
    end
    if (cmd.store) begin
      if (cmd.chan) res_r <= quot;
      else          res_l <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      left_out   <= scale_en ? res_l : (zero_l ? '0 : sample_l);
      right_out  <= scale_en ? res_r : sample_r;
      mode_error <= err;
    end
  end

  assign status.scale_en = scale_en;
  assign status.div_last = (step_cnt == pfp_pkg::STEP_W'(QB - 1));
  assign status.out_free = !out_valid || !out_stall;

  `ASSERT_IMPLIES(a_rem_below_den, clk, rst, cmd.step, (rem < den))
  `ASSERT_IMPLIES(a_quot_fits, clk, rst, cmd.store, (qsh[QB-1] == 1'b0))
  `ASSERT_IMPLIES(a_den_nonzero, clk, rst, cmd.mul, (scale_en && den != '0))

endmodule

@@ rtl/core/pcm_fade_and_pan_envelope_unit.sv @@
// Top level of the PCM fade and pan envelope unit
//
//  port group   dir  handshake          payload
//  in           in   in_valid/in_stall  left_sample, right_sample
//  out          out  out_valid/out_stall left_out, right_out, mode_error
//  cfg          in   cfg_en             cfg_addr, cfg_data
//
//  An item that needs scaling, from accept to output register, takes
//  one multiply and a 16-step restoring divide per channel on a shared divider.
//  An item that passes through or is zeroed skips the multiply and divide.
//  The next item is taken while the previous result waits in the output register.
//  Active-high sync reset clears config (stereo on), frame counters, handshakes.
//  A stalled output holds the finished item back only once the next one is done.

module pcm_fade_and_pan_envelope_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_en,
  input  logic [pfp_pkg::ADDR_W-1:0]          cfg_addr,
  input  logic [pfp_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pfp_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [pfp_pkg::SAMPLE_W-1:0] right_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pfp_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [pfp_pkg::SAMPLE_W-1:0] right_out,
  output logic                                mode_error
);

  pfp_pkg::pfp_cmd_t    cmd;
  pfp_pkg::pfp_status_t status;

  pfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pfp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_en       (cfg_en),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_out     (left_out),
    .right_out    (right_out),
    .mode_error   (mode_error),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
